// File: rtl/mhtq_pkg.sv
package mhtq_pkg;

  localparam int KIND_W = 3;
  localparam int ID_W   = 10;
  localparam int TMO_W  = 20;
  localparam int ELP_W  = 16;
  localparam int STAT_W = 2;
  localparam int WAIT_W = 20;
  localparam int LIVE_W = 7;
  localparam int TIME_W = 32;

  localparam logic [KIND_W-1:0] KIND_ADD   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DEL   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ADJ   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_TICK  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_UNKNOWN = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   timer_id;
    logic [TMO_W-1:0]  timeout_ms;
    logic [ELP_W-1:0]  elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic              fired;
    logic [ID_W-1:0]   expired_id;
    logic [STAT_W-1:0] status;
    logic              queue_empty;
    logic [WAIT_W-1:0] next_wait_ms;
    logic [LIVE_W-1:0] live_count;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] exp;
  } heap_ent_t;

  typedef struct packed {
    logic              lt;
    logic [TIME_W-1:0] diff;
    logic [TIME_W-1:0] sum;
  } alu_res_t;

endpackage

// File: rtl/mhtq_if.sv
interface mhtq_in_if import mhtq_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mhtq_out_if import mhtq_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/mhtq_alu.sv
module mhtq_alu import mhtq_pkg::*; (
  input  logic [TIME_W-1:0] a,
  input  logic [TIME_W-1:0] b,
  output alu_res_t          res
);
  logic [TIME_W:0] s;

  assign s        = {1'b0, a} + {1'b0, b};
  assign res.lt   = a < b;
  assign res.diff = b - a;
  // saturate instead of wrap
  assign res.sum  = s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
endmodule

// File: rtl/min_heap_timer_queue_top.sv
// Channel   Dir  Beat payload
// in_chan   in   kind, timer_id, timeout_ms, elapsed_ms
// out_chan  out  fired, expired_id, status, queue_empty, next_wait_ms, live_count, last
//
// One operation at a time: lookup (map read, then heap read), sift levels through the
// single heap read port (up: UP0, UP1; down: DN0 to DN3), place, finish, then EMRD and
// EMIT per result beat. A tick tests the root (POPR, POPC); each pop refills the root,
// sifts it down and places it. After reset the id map is swept once, in_chan.ready low.
// Results sit in an output register; a stalled out_chan holds the sequencer in its
// emit state, and the next beat can be accepted while the final result still waits.
module min_heap_timer_queue_top import mhtq_pkg::*; #(
  parameter int CAPACITY = 64,
  parameter int ID_SPACE = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  mhtq_in_if.sink     in_chan,
  mhtq_out_if.source  out_chan
);

  localparam int SW = $clog2(CAPACITY);      // heap slot index
  localparam int CW = $clog2(CAPACITY + 1);  // entry count
  localparam int IW = $clog2(ID_SPACE);      // id map index
  localparam int XW = SW + 2;                // child index, may run past the heap

  localparam logic [4:0] ST_CLR   = 5'd0;
  localparam logic [4:0] ST_IDLE  = 5'd1;
  localparam logic [4:0] ST_LOOK  = 5'd2;
  localparam logic [4:0] ST_CHK   = 5'd3;
  localparam logic [4:0] ST_LDM   = 5'd4;
  localparam logic [4:0] ST_DN0   = 5'd5;
  localparam logic [4:0] ST_DN1   = 5'd6;
  localparam logic [4:0] ST_DN2   = 5'd7;
  localparam logic [4:0] ST_DN3   = 5'd8;
  localparam logic [4:0] ST_UP0   = 5'd9;
  localparam logic [4:0] ST_UP1   = 5'd10;
  localparam logic [4:0] ST_PLACE = 5'd11;
  localparam logic [4:0] ST_POPR  = 5'd12;
  localparam logic [4:0] ST_POPC  = 5'd13;
  localparam logic [4:0] ST_FIN   = 5'd14;
  localparam logic [4:0] ST_WT    = 5'd15;
  localparam logic [4:0] ST_EMRD  = 5'd16;
  localparam logic [4:0] ST_EMIT  = 5'd17;

  // control state
  logic [4:0]        st_r, st_nxt;
  logic [IW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic              out_valid_r, out_valid_nxt;

  // operation payload
  logic [KIND_W-1:0] op_r, op_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic              in_space_r, in_space_nxt;
  logic [TIME_W-1:0] exp_new_r, exp_new_nxt;
  logic [SW-1:0]     slot_r, slot_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [SW-1:0]     i_r, i_nxt;        // hole position
  heap_ent_t         m_r, m_nxt;        // entry being sifted
  heap_ent_t         l_r, l_nxt;        // left child
  heap_ent_t         ch_r, ch_nxt;      // chosen child
  logic [SW-1:0]     cidx_r, cidx_nxt;
  logic [XW-1:0]     c_r, c_nxt;
  logic [SW-1:0]     p_r, p_nxt;
  logic              moved_r, moved_nxt;
  logic [CW-1:0]     nfired_r, nfired_nxt;
  logic [CW-1:0]     ek_r, ek_nxt;
  logic [WAIT_W-1:0] wait_r, wait_nxt;
  out_item_t         out_r, out_nxt;
  logic              out_load;

  // memories
  heap_ent_t         heap_mem [CAPACITY];
  logic [SW-1:0]     map_mem  [ID_SPACE];
  logic [ID_W-1:0]   fm_mem   [CAPACITY];
  heap_ent_t         hp_q;
  logic [SW-1:0]     mp_q;
  logic [ID_W-1:0]   fm_q;

  logic              hp_we;
  logic [SW-1:0]     hp_waddr, hp_raddr;
  heap_ent_t         hp_wdata;
  logic              mp_we;
  logic [IW-1:0]     mp_waddr, mp_raddr;
  logic [SW-1:0]     mp_wdata;
  logic              fm_we;

  // shared compare / subtract / saturating add
  logic [TIME_W-1:0] alu_a, alu_b;
  alu_res_t          alu;

  mhtq_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .res (alu)
  );

  logic [16:0]   id_ext;
  logic [XW-1:0] count_x, c_first, c_next;
  logic [CW-1:0] cnt_m1, nres, ek_p1;
  logic [SW-1:0] last_slot, par;
  logic          known, out_free;

  assign id_ext    = 17'(in_chan.data.timer_id);
  assign count_x   = XW'(count_r);
  assign c_first   = {1'b0, i_r, 1'b1};
  assign c_next    = c_r + XW'(1);
  assign cnt_m1    = count_r - CW'(1);
  assign last_slot = cnt_m1[SW-1:0];
  assign par       = SW'((i_r - SW'(1)) >> 1);
  // map entries may be stale: an id is held only if its slot points back at it
  assign known     = in_space_r && (CW'(slot_r) < count_r) && (hp_q.id == id_r);
  assign nres      = (nfired_r == '0) ? CW'(1) : nfired_r;
  assign ek_p1     = ek_r + CW'(1);
  assign out_free  = !out_valid_r || out_chan.ready;
  assign mp_raddr  = IW'(id_ext);

  assign in_chan.ready  = (st_r == ST_IDLE);
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_r;

  always_comb begin
    alu_a = now_r;
    alu_b = hp_q.exp;
    case (st_r)
      ST_IDLE: alu_b = (in_chan.data.kind == KIND_TICK) ? TIME_W'(in_chan.data.elapsed_ms)
                                                        : TIME_W'(in_chan.data.timeout_ms);
      ST_DN2: begin
        alu_a = hp_q.exp;
        alu_b = l_r.exp;
      end
      ST_DN3: begin
        alu_a = ch_r.exp;
        alu_b = m_r.exp;
      end
      ST_UP1: begin
        alu_a = m_r.exp;
        alu_b = hp_q.exp;
      end
      default: ;
    endcase
  end

  always_comb begin
    st_nxt       = st_r;
    clr_cnt_nxt  = clr_cnt_r;
    count_nxt    = count_r;
    now_nxt      = now_r;
    op_nxt       = op_r;
    id_nxt       = id_r;
    in_space_nxt = in_space_r;
    exp_new_nxt  = exp_new_r;
    slot_nxt     = slot_r;
    status_nxt   = status_r;
    i_nxt        = i_r;
    m_nxt        = m_r;
    l_nxt        = l_r;
    ch_nxt       = ch_r;
    cidx_nxt     = cidx_r;
    c_nxt        = c_r;
    p_nxt        = p_r;
    moved_nxt    = moved_r;
    nfired_nxt   = nfired_r;
    ek_nxt       = ek_r;
    wait_nxt     = wait_r;
    out_load     = 1'b0;
    hp_we        = 1'b0;
    hp_waddr     = i_r;
    hp_wdata     = m_r;
    hp_raddr     = '0;
    mp_we        = 1'b0;
    mp_waddr     = IW'(m_r.id);
    mp_wdata     = i_r;
    fm_we        = 1'b0;

    case (st_r)
      ST_CLR: begin
        mp_we       = 1'b1;
        mp_waddr    = clr_cnt_r;
        mp_wdata    = '0;
        clr_cnt_nxt = clr_cnt_r + IW'(1);
        if (clr_cnt_r == IW'(ID_SPACE - 1)) begin
          st_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_chan.valid) begin
          op_nxt       = in_chan.data.kind;
          id_nxt       = in_chan.data.timer_id;
          in_space_nxt = id_ext < 17'(ID_SPACE);
          status_nxt   = STAT_OK;
          nfired_nxt   = '0;
          if (in_chan.data.kind == KIND_TICK) begin
            now_nxt = alu.sum;
          end else begin
            exp_new_nxt = alu.sum;
          end
          st_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        slot_nxt = mp_q;
        hp_raddr = mp_q;
        st_nxt   = ST_CHK;
      end
      ST_CHK: begin
        case (op_r)
          KIND_ADD, KIND_ADJ: begin
            if (known) begin
              m_nxt     = '{id: id_r, exp: exp_new_r};
              i_nxt     = slot_r;
              moved_nxt = 1'b0;
              st_nxt    = ST_DN0;
            end else if (op_r == KIND_ADD && in_space_r) begin
              if (count_r == CW'(CAPACITY)) begin
                status_nxt = STAT_FULL;
                st_nxt     = ST_FIN;
              end else begin
                m_nxt     = '{id: id_r, exp: exp_new_r};
                i_nxt     = count_r[SW-1:0];
                count_nxt = count_r + CW'(1);
                st_nxt    = ST_UP0;
              end
            end else begin
              if (op_r == KIND_ADJ) begin
                status_nxt = STAT_UNKNOWN;
              end
              st_nxt = ST_FIN;
            end
          end
          KIND_DEL: begin
            if (known) begin
              count_nxt = cnt_m1;
              if (slot_r == last_slot) begin
                st_nxt = ST_FIN;
              end else begin
                hp_raddr = last_slot;
                i_nxt    = slot_r;
                st_nxt   = ST_LDM;
              end
            end else begin
              st_nxt = ST_FIN;
            end
          end
          KIND_TICK: st_nxt = ST_POPR;
          KIND_CLEAR: begin
            count_nxt = '0;
            st_nxt    = ST_FIN;
          end
          default: st_nxt = ST_FIN;
        endcase
      end
      ST_LDM: begin
        // last entry fills the hole, then resift
        m_nxt     = hp_q;
        moved_nxt = 1'b0;
        st_nxt    = ST_DN0;
      end
      ST_DN0: begin
        if (c_first >= count_x) begin
          st_nxt = moved_r ? ST_PLACE : ST_UP0;
        end else begin
          hp_raddr = c_first[SW-1:0];
          c_nxt    = c_first;
          st_nxt   = ST_DN1;
        end
      end
      ST_DN1: begin
        l_nxt = hp_q;
        if (c_next < count_x) begin
          hp_raddr = c_next[SW-1:0];
          st_nxt   = ST_DN2;
        end else begin
          ch_nxt   = hp_q;
          cidx_nxt = c_r[SW-1:0];
          st_nxt   = ST_DN3;
        end
      end
      ST_DN2: begin
        // right child only when strictly smaller
        if (alu.lt) begin
          ch_nxt   = hp_q;
          cidx_nxt = c_next[SW-1:0];
        end else begin
          ch_nxt   = l_r;
          cidx_nxt = c_r[SW-1:0];
        end
        st_nxt = ST_DN3;
      end
      ST_DN3: begin
        if (alu.lt) begin
          hp_we     = 1'b1;
          hp_wdata  = ch_r;
          mp_we     = 1'b1;
          mp_waddr  = IW'(ch_r.id);
          i_nxt     = cidx_r;
          moved_nxt = 1'b1;
          st_nxt    = ST_DN0;
        end else begin
          st_nxt = moved_r ? ST_PLACE : ST_UP0;
        end
      end
      ST_UP0: begin
        if (i_r == '0) begin
          st_nxt = ST_PLACE;
        end else begin
          hp_raddr = par;
          p_nxt    = par;
          st_nxt   = ST_UP1;
        end
      end
      ST_UP1: begin
        if (alu.lt) begin
          hp_we    = 1'b1;
          hp_wdata = hp_q;
          mp_we    = 1'b1;
          mp_waddr = IW'(hp_q.id);
          i_nxt    = p_r;
          st_nxt   = ST_UP0;
        end else begin
          st_nxt = ST_PLACE;
        end
      end
      ST_PLACE: begin
        hp_we  = 1'b1;
        mp_we  = 1'b1;
        st_nxt = (op_r == KIND_TICK) ? ST_POPR : ST_FIN;
      end
      ST_POPR: begin
        if (count_r == '0) begin
          st_nxt = ST_FIN;
        end else begin
          hp_raddr = '0;
          st_nxt   = ST_POPC;
        end
      end
      ST_POPC: begin
        // root expired when now >= exp
        if (!alu.lt) begin
          fm_we      = 1'b1;
          nfired_nxt = nfired_r + CW'(1);
          count_nxt  = cnt_m1;
          if (cnt_m1 == '0) begin
            st_nxt = ST_POPR;
          end else begin
            hp_raddr = last_slot;
            i_nxt    = '0;
            st_nxt   = ST_LDM;
          end
        end else begin
          st_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        hp_raddr = '0;
        st_nxt   = ST_WT;
      end
      ST_WT: begin
        wait_nxt = (count_r != '0 && alu.lt) ? alu.diff[WAIT_W-1:0] : '0;
        ek_nxt   = '0;
        st_nxt   = ST_EMRD;
      end
      ST_EMRD: st_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (ek_p1 == nres) begin
            st_nxt = ST_IDLE;
          end else begin
            ek_nxt = ek_p1;
            st_nxt = ST_EMRD;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_nxt.fired        = (nfired_r != '0);
    out_nxt.expired_id   = (nfired_r != '0) ? fm_q : '0;
    out_nxt.status       = status_r;
    out_nxt.queue_empty  = (count_r == '0);
    out_nxt.next_wait_ms = wait_r;
    out_nxt.live_count   = LIVE_W'(count_r);
    out_nxt.last         = (ek_p1 == nres);
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_chan.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLR;
      clr_cnt_r   <= '0;
      count_r     <= '0;
      now_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      count_r     <= count_nxt;
      now_r       <= now_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    id_r       <= id_nxt;
    in_space_r <= in_space_nxt;
    exp_new_r  <= exp_new_nxt;
    slot_r     <= slot_nxt;
    status_r   <= status_nxt;
    i_r        <= i_nxt;
    m_r        <= m_nxt;
    l_r        <= l_nxt;
    ch_r       <= ch_nxt;
    cidx_r     <= cidx_nxt;
    c_r        <= c_nxt;
    p_r        <= p_nxt;
    moved_r    <= moved_nxt;
    nfired_r   <= nfired_nxt;
    ek_r       <= ek_nxt;
    wait_r     <= wait_nxt;
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (hp_we) begin
      heap_mem[hp_waddr] <= hp_wdata;
    end
    hp_q <= heap_mem[hp_raddr];
  end

  always_ff @(posedge clk) begin
    if (mp_we) begin
      map_mem[mp_waddr] <= mp_wdata;
    end
    mp_q <= map_mem[mp_raddr];
  end

  // ids fired during a tick, replayed once the final state is known
  always_ff @(posedge clk) begin
    if (fm_we) begin
      fm_mem[nfired_r[SW-1:0]] <= hp_q.id;
    end
    fm_q <= fm_mem[ek_r[SW-1:0]];
  end

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_place_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_PLACE) |-> (CW'(i_r) < count_r))
    else $error("sift places entry outside live heap");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> (st_r == ST_LOOK))
    else $error("accepted beat not started");

  a_fired_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_EMIT && nfired_r != '0) |-> (op_r == KIND_TICK))
    else $error("fired result outside a tick");

endmodule

// File: verif/mhtq_checker.sv
`timescale 1ns / 100ps

// Watches both channels. Keeps its own heap model and checks each result beat in order.
module mhtq_checker import mhtq_pkg::*; #(
  parameter int CAPACITY = 64,
  parameter int ID_SPACE = 1024
) (
  input  logic  clk,
  input  logic  rst_n,
  mhtq_in_if    in_mon,
  mhtq_out_if   out_mon,
  output int    fail_cnt,
  output int    pending
);

  logic [ID_W-1:0]   heap_id [CAPACITY];
  logic [TIME_W-1:0] heap_exp [CAPACITY];
  int                slot_of [ID_SPACE];
  bit                held [ID_SPACE];
  int                live;
  logic [TIME_W-1:0] now_ms;
  out_item_t         beat_q[$];

  assign pending = beat_q.size();

  function automatic logic [TIME_W-1:0] sat_sum(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

  function automatic void swap_ent(int a, int b);
    logic [ID_W-1:0]   ti;
    logic [TIME_W-1:0] te;
    ti = heap_id[a];
    te = heap_exp[a];
    heap_id[a] = heap_id[b];
    heap_exp[a] = heap_exp[b];
    heap_id[b] = ti;
    heap_exp[b] = te;
    slot_of[heap_id[a]] = a;
    slot_of[heap_id[b]] = b;
  endfunction

  function automatic void bubble_up(int i);
    int p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (heap_exp[p] <= heap_exp[i]) break;
      swap_ent(i, p);
      i = p;
    end
  endfunction

  function automatic bit bubble_down(int i);
    int c;
    int start;
    start = i;
    forever begin
      c = 2 * i + 1;
      if (c >= live) break;
      if (c + 1 < live && heap_exp[c+1] < heap_exp[c]) c++;
      if (heap_exp[i] <= heap_exp[c]) break;
      swap_ent(i, c);
      i = c;
    end
    return i > start;
  endfunction

  function automatic void reorder(int i);
    if (!bubble_down(i)) bubble_up(i);
  endfunction

  function automatic void drop_slot(int i);
    int tail;
    tail = live - 1;
    held[heap_id[i]] = 0;
    if (i != tail) begin
      heap_id[i] = heap_id[tail];
      heap_exp[i] = heap_exp[tail];
      slot_of[heap_id[i]] = i;
    end
    live = tail;
    if (i < live) reorder(i);
  endfunction

  // Applies one operation and queues the result beats it should produce.
  function automatic void run_op(in_item_t op);
    logic [ID_W-1:0]   popped[$];
    logic [STAT_W-1:0] stat;
    logic [TIME_W-1:0] wait_ms;
    bit                known;
    int                s;
    int                n;
    out_item_t         b;
    stat = STAT_OK;
    known = op.timer_id < ID_SPACE && held[op.timer_id];
    case (op.kind)
      KIND_ADD: begin
        if (known) begin
          s = slot_of[op.timer_id];
          heap_exp[s] = sat_sum(now_ms, TIME_W'(op.timeout_ms));
          reorder(s);
        end else if (op.timer_id < ID_SPACE) begin
          if (live >= CAPACITY) begin
            stat = STAT_FULL;
          end else begin
            s = live;
            heap_id[s] = op.timer_id;
            heap_exp[s] = sat_sum(now_ms, TIME_W'(op.timeout_ms));
            slot_of[op.timer_id] = s;
            held[op.timer_id] = 1;
            live = s + 1;
            bubble_up(s);
          end
        end
      end
      KIND_DEL: begin
        if (known) drop_slot(slot_of[op.timer_id]);
      end
      KIND_ADJ: begin
        if (known) begin
          s = slot_of[op.timer_id];
          heap_exp[s] = sat_sum(now_ms, TIME_W'(op.timeout_ms));
          reorder(s);
        end else begin
          stat = STAT_UNKNOWN;
        end
      end
      KIND_TICK: begin
        now_ms = sat_sum(now_ms, TIME_W'(op.elapsed_ms));
        while (live > 0 && heap_exp[0] <= now_ms && popped.size() < CAPACITY) begin
          popped = {popped, heap_id[0]};
          drop_slot(0);
        end
      end
      KIND_CLEAR: begin
        foreach (held[k]) held[k] = 0;
        live = 0;
      end
      default: ;
    endcase
    wait_ms = (live > 0 && heap_exp[0] > now_ms) ? heap_exp[0] - now_ms : '0;
    n = popped.size() > 0 ? popped.size() : 1;
    for (int k = 0; k < n; k++) begin
      b.fired        = popped.size() > 0;
      b.expired_id   = popped.size() > 0 ? popped[k] : '0;
      b.status       = stat;
      b.queue_empty  = live == 0;
      b.next_wait_ms = wait_ms[WAIT_W-1:0];
      b.live_count   = LIVE_W'(live);
      b.last         = k + 1 == n;
      beat_q = {beat_q, b};
    end
  endfunction

  task automatic report(string what, logic [31:0] exp_v, logic [31:0] act_v);
    fail_cnt++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, act_v);
  endtask

  initial begin
    fail_cnt = 0;
    live = 0;
    now_ms = '0;
    foreach (held[k]) held[k] = 0;
  end

  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready) run_op(in_mon.data);
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.data;
        if (beat_q.size() == 0) begin
          fail_cnt++;
          $display("%0t: unexpected result beat, expected none, got %h", $time, got);
        end else begin
          want = beat_q.pop_front();
          if (got.fired !== want.fired) report("fired", want.fired, got.fired);
          if (got.expired_id !== want.expired_id)
            report("expired_id", want.expired_id, got.expired_id);
          if (got.status !== want.status) report("status", want.status, got.status);
          if (got.queue_empty !== want.queue_empty)
            report("queue_empty", want.queue_empty, got.queue_empty);
          if (got.next_wait_ms !== want.next_wait_ms)
            report("next_wait_ms", want.next_wait_ms, got.next_wait_ms);
          if (got.live_count !== want.live_count)
            report("live_count", want.live_count, got.live_count);
          if (got.last !== want.last) report("last", want.last, got.last);
        end
      end
    end
  end

endmodule

// File: verif/min_heap_timer_queue_top_tb.sv
`timescale 1ns / 100ps

module min_heap_timer_queue_top_tb;
  import mhtq_pkg::*;

  logic clk;
  logic rst_n;
  int   fail_cnt;
  int   pending;
  bit   in_busy_mode;   // when clear, the source sends back to back
  bit   out_busy_mode;  // when clear, the sink never stalls

  mhtq_in_if  in_if ();
  mhtq_out_if out_if ();

  min_heap_timer_queue_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  mhtq_checker u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_mon   (in_if),
    .out_mon  (out_if),
    .fail_cnt (fail_cnt),
    .pending  (pending)
  );

  initial clk = 0;
  always #6 clk = ~clk;

  // Ids come mostly from a small pool so restarts, deletes and a full heap all happen.
  function automatic logic [ID_W-1:0] pick_id();
    if ($urandom_range(0, 9) == 0) return ID_W'($urandom);
    return ID_W'($urandom_range(0, 79) * 13);
  endfunction

  function automatic logic [TMO_W-1:0] pick_tmo();
    case ($urandom_range(0, 9))
      0: return '1;
      1: return TMO_W'($urandom);
      2: return '0;
      default: return TMO_W'($urandom_range(1, 3000));
    endcase
  endfunction

  function automatic logic [ELP_W-1:0] pick_elapsed();
    case ($urandom_range(0, 9))
      0: return '1;
      1: return ELP_W'($urandom);
      2: return '0;
      default: return ELP_W'($urandom_range(1, 600));
    endcase
  endfunction

  function automatic in_item_t make_op(logic [KIND_W-1:0] k, logic [ID_W-1:0] id,
                                       logic [TMO_W-1:0] tmo, logic [ELP_W-1:0] elp);
    in_item_t op;
    op.kind = k;
    op.timer_id = id;
    op.timeout_ms = tmo;
    op.elapsed_ms = elp;
    return op;
  endfunction

  // One beat on in_chan, then the random gap before the next one.
  task automatic push_op(in_item_t op);
    int gap;
    in_if.data  <= op;
    in_if.valid <= 1'b1;
    do @(posedge clk); while (!in_if.ready);
    if ($urandom_range(0, 39) == 0) in_busy_mode = ~in_busy_mode;
    gap = in_busy_mode ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Result sink: in busy mode, hold ready low for a random stall after each beat.
  initial begin
    int stall;
    out_if.ready  = 1'b0;
    out_busy_mode = 1;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    out_if.ready <= 1'b1;
    forever begin
      do @(posedge clk); while (!out_if.valid);
      if ($urandom_range(0, 39) == 0) out_busy_mode = ~out_busy_mode;
      stall = out_busy_mode ? $urandom_range(0, 10) : 0;
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    int r;
    in_item_t op;
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    in_busy_mode = 1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, every kind, unknown ids, unused kinds.
    push_op(make_op(KIND_ADD, 10'd0, '0, '1));              // expires right away
    push_op(make_op(KIND_ADD, 10'd1023, '1, '0));           // widest id and timeout
    push_op(make_op(KIND_ADD, 10'd5, 20'd100, '0));
    push_op(make_op(KIND_ADD, 10'd5, 20'd50, '0));          // restart existing id
    push_op(make_op(KIND_ADJ, 10'd5, 20'd10, '0));
    push_op(make_op(KIND_ADJ, 10'd777, 20'd7, '0));         // unknown id
    push_op(make_op(KIND_DEL, 10'd999, '0, '0));            // delete unknown, ignored
    push_op(make_op(KIND_ADD, 10'd682, 20'd10, '0));        // tie on expiry
    push_op(make_op(KIND_DEL, 10'd1023, '0, '0));
    push_op(make_op(3'd5, 10'h2AA, 20'hAAAAA, 16'hAAAA));   // unused kinds
    push_op(make_op(3'd6, 10'h155, 20'h55555, 16'h5555));
    push_op(make_op(3'd7, 10'h3FF, '1, '1));
    push_op(make_op(KIND_TICK, '0, '0, 16'd0));             // pops id 0
    push_op(make_op(KIND_TICK, '0, '0, 16'd9));             // nothing due yet
    push_op(make_op(KIND_TICK, '0, '0, 16'd1));             // two timers fire together
    push_op(make_op(KIND_ADD, 10'd3, 20'd40, '0));
    push_op(make_op(KIND_ADD, 10'd4, 20'd20, '0));
    push_op(make_op(KIND_ADD, 10'd6, 20'd30, '0));
    push_op(make_op(KIND_TICK, '0, '0, '1));                // pops all in order
    push_op(make_op(KIND_ADD, 10'd8, 20'd30, '0));
    push_op(make_op(KIND_CLEAR, '0, '0, '0));
    push_op(make_op(KIND_TICK, '0, '0, 16'd3));             // tick on empty
    push_op(make_op(KIND_ADJ, 10'd8, 20'd1, '0));           // cleared id is unknown

    // Random: add heavy so the heap often fills, with ticks draining it.
    for (int n = 0; n < 260; n++) begin
      r = $urandom_range(0, 99);
      if (r < 45)      op = make_op(KIND_ADD, pick_id(), pick_tmo(), ELP_W'($urandom));
      else if (r < 60) op = make_op(KIND_DEL, pick_id(), TMO_W'($urandom), ELP_W'($urandom));
      else if (r < 73) op = make_op(KIND_ADJ, pick_id(), pick_tmo(), ELP_W'($urandom));
      else if (r < 95) op = make_op(KIND_TICK, ID_W'($urandom), TMO_W'($urandom),
                                    pick_elapsed());
      else if (r < 97) op = make_op(KIND_CLEAR, ID_W'($urandom), TMO_W'($urandom),
                                    ELP_W'($urandom));
      else op = make_op(KIND_W'($urandom_range(5, 7)), ID_W'($urandom),
                        TMO_W'($urandom), ELP_W'($urandom));
      push_op(op);
    end
    in_if.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_cnt == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // Watchdog: covers the id map sweep and worst-case pops with stalls, many times over.
  initial begin
    #30ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
